// ===== hw/rtl/frame_reorder_jitter_buffer_top_defines.svh =====
// assertion macros for the frame reorder jitter buffer
`ifndef FRAME_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH
`define FRAME_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FRJB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FRJB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frjb_pkg.sv =====
package frjb_pkg;

  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int TS_W       = 32;
  localparam int SEQ_W      = 16;
  localparam int LEN_W      = 16;
  localparam int TAG_W      = 16;
  localparam int SUM_W      = 20;
  localparam int OCNT_W     = 5;
  localparam int CFG_W      = 5;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_LATE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOPOP    = 3'd4;
  localparam logic [STAT_W-1:0] ST_FLUSHED  = 3'd5;

endpackage

// ===== hw/rtl/frjb_ram.sv =====
module frjb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/frame_reorder_jitter_buffer_top.sv =====
// push: scan held frames, compare packets in a matching frame and move slots, or open a new
//   frame when none matches; pop: read the oldest frame and stream one beat per packet; flush:
//   read the newest stamp; late push, empty flush or refused pop give a single-beat result
// throughput: one item at a time, set by the sequencer sharing one read port per memory; a pop
//   stays busy after its last beat while it closes the gap in the order table; result stalls
//   hold the sequencer further; reset: synchronous, active high, clears counts and flags, then
//   the slot order table is loaded, no beat taken
`include "frame_reorder_jitter_buffer_top_defines.svh"

module frame_reorder_jitter_buffer_top #(
  parameter int MAX_FRAMES  = 16,
  parameter int MAX_PACKETS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [frjb_pkg::CFG_W-1:0]         cfg_wdata,     // start_length
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // timestamp, seq_number, byte_length, nal_start, packet_tag, zero pad
  input  logic [frjb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [frjb_pkg::OP_W-1:0]          s_axis_tuser,  // opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // frame_stamp, out_tag, out_seq, frame_bytes, nal_total, packets_in_frame, zero pad
  output logic [frjb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [frjb_pkg::STAT_W-1:0]        m_axis_tuser,  // status
  output logic                               m_axis_tlast
);

  import frjb_pkg::*;

  // slot index, held count, packet index, packet count widths
  localparam int FW = $clog2(MAX_FRAMES);
  localparam int HW = $clog2(MAX_FRAMES + 1);
  localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int SW = (HW > CFG_W) ? HW : CFG_W;
  localparam int MW = TS_W + SUM_W + 2 * CW;
  localparam int PKW = TAG_W + SEQ_W;
  localparam int PDEPTH = MAX_FRAMES * (2 ** PW);

  // sequencer states
  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_SC_ORD   = 5'd2;
  localparam logic [4:0] S_SC_META  = 5'd3;
  localparam logic [4:0] S_SC_CMP   = 5'd4;
  localparam logic [4:0] S_NF_RD    = 5'd5;
  localparam logic [4:0] S_NF_GET   = 5'd6;
  localparam logic [4:0] S_OSH_RD   = 5'd7;
  localparam logic [4:0] S_OSH_WR   = 5'd8;
  localparam logic [4:0] S_SQ_RD    = 5'd9;
  localparam logic [4:0] S_SQ_CMP   = 5'd10;
  localparam logic [4:0] S_PSH_RD   = 5'd11;
  localparam logic [4:0] S_PSH_WR   = 5'd12;
  localparam logic [4:0] S_EMIT     = 5'd13;
  localparam logic [4:0] S_POP_ORD  = 5'd14;
  localparam logic [4:0] S_POP_META = 5'd15;
  localparam logic [4:0] S_POP_LD   = 5'd16;
  localparam logic [4:0] S_POP_RD   = 5'd17;
  localparam logic [4:0] S_POP_OUT  = 5'd18;
  localparam logic [4:0] S_OD_RD    = 5'd19;
  localparam logic [4:0] S_OD_WR    = 5'd20;
  localparam logic [4:0] S_FL_ORD   = 5'd21;
  localparam logic [4:0] S_FL_META  = 5'd22;
  localparam logic [4:0] S_FL_LD    = 5'd23;

  logic [4:0] state;

  // persistent state
  logic [HW-1:0]    held;
  logic             started;
  logic [TS_W-1:0]  lps;          // last popped or flushed stamp
  logic [CFG_W-1:0] start_len;
  logic [HW-1:0]    clr;

  // latched input beat
  logic [TS_W-1:0]  ts;
  logic [SEQ_W-1:0] sq;
  logic [LEN_W-1:0] blen;
  logic             nal;
  logic [TAG_W-1:0] tag;

  // working registers
  logic [HW-1:0]    fi;
  logic [HW-1:0]    fp;
  logic [TS_W:0]    fd;           // wrap-extended stamp for frame ordering
  logic             fstop;
  logic [FW-1:0]    slot;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    nalc;
  logic [SUM_W-1:0] sum;
  logic [TS_W-1:0]  mstamp;
  logic [CW-1:0]    pj;
  logic [CW-1:0]    pp;
  logic [SEQ_W:0]   sd;           // wrap-extended sequence for packet ordering
  logic [STAT_W-1:0] res_status;
  logic [TS_W-1:0]  res_stamp;

  // output register
  logic              m_valid;
  logic [STAT_W-1:0] m_status;
  logic [TS_W-1:0]   m_stamp;
  logic [TAG_W-1:0]  m_tag;
  logic [SEQ_W-1:0]  m_seq;
  logic [SUM_W-1:0]  m_bytes;
  logic [OCNT_W-1:0] m_nal;
  logic [OCNT_W-1:0] m_pk;
  logic              m_last;
  logic              ofree;
  logic              beat_load;

  // memories
  logic           ord_we;
  logic [FW-1:0]  ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic           meta_we;
  logic [FW-1:0]  meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic           pkt_we;
  logic [FW+PW-1:0] pkt_waddr, pkt_raddr;
  logic [PKW-1:0] pkt_wdata, pkt_rdata;

  // decoded memory reads
  logic [TS_W-1:0]  m_rd_stamp;
  logic [SUM_W-1:0] m_rd_sum;
  logic [CW-1:0]    m_rd_nal;
  logic [CW-1:0]    m_rd_cnt;
  logic [SEQ_W-1:0] p_rd_seq;

  // helpers
  logic [HW-1:0] fim1, heldm1, heldp1;
  logic [CW-1:0] pjm1, pjp1;
  logic [TS_W:0] f_ns, f_adj, f_fwd;
  logic [TS_W-1:0] f_back;
  logic          f_adv;
  logic [SEQ_W:0] s_ps, s_adj, s_fwd;
  logic [SEQ_W-1:0] s_back;
  logic          s_adv;
  logic [TS_W:0] late_fwd;
  logic [TS_W-1:0] late_back;
  logic          late;
  logic [SUM_W:0] sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [CW-1:0] nal_ext;
  logic          start_new, start_same;

  function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CW-1:0] v);
    sat_cnt = (32'(v) > 32'd31) ? 5'd31 : OCNT_W'(v);
  endfunction

  assign m_rd_stamp = meta_rdata[TS_W-1:0];
  assign m_rd_sum   = meta_rdata[TS_W+SUM_W-1:TS_W];
  assign m_rd_nal   = meta_rdata[TS_W+SUM_W+CW-1:TS_W+SUM_W];
  assign m_rd_cnt   = meta_rdata[MW-1:TS_W+SUM_W+CW];
  assign p_rd_seq   = pkt_rdata[SEQ_W-1:0];

  assign fim1   = fi - HW'(1);
  assign heldm1 = held - HW'(1);
  assign heldp1 = held + HW'(1);
  assign pjm1   = pj - CW'(1);
  assign pjp1   = pj + CW'(1);

  // wrap-aware frame step: bump by 2^32 when forward across the wrap is closer
  assign f_ns   = {1'b0, m_rd_stamp};
  assign f_fwd  = {1'b1, fd[TS_W-1:0]} - f_ns;
  assign f_back = m_rd_stamp - fd[TS_W-1:0];
  always_comb begin
    f_adj = fd;
    if ((fd < f_ns) && (f_fwd < {1'b0, f_back})) begin
      f_adj[TS_W] = 1'b1;
    end
  end
  assign f_adv = f_ns < f_adj;

  // same walk over 16-bit sequence numbers
  assign s_ps   = {1'b0, p_rd_seq};
  assign s_fwd  = {1'b1, sd[SEQ_W-1:0]} - s_ps;
  assign s_back = p_rd_seq - sd[SEQ_W-1:0];
  always_comb begin
    s_adj = sd;
    if ((sd < s_ps) && (s_fwd < {1'b0, s_back})) begin
      s_adj[SEQ_W] = 1'b1;
    end
  end
  assign s_adv = s_ps < s_adj;

  // late check against the last popped stamp, on the incoming beat
  assign late_fwd  = {1'b1, s_axis_tdata[TS_W-1:0]} - {1'b0, lps};
  assign late_back = lps - s_axis_tdata[TS_W-1:0];
  assign late = (s_axis_tdata[TS_W-1:0] < lps) && !(late_fwd < {1'b0, late_back});

  // running totals with saturation of the byte sum
  assign sum_add = (SUM_W + 1)'(sum) + (SUM_W + 1)'(blen);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign nal_ext = CW'(nal);

  assign start_new  = SW'(heldp1) >= SW'(start_len);
  assign start_same = SW'(held) >= SW'(start_len);

  assign ofree = !m_valid || m_axis_tready;
  // a result beat is loaded into the output register this cycle
  assign beat_load = ofree && ((state == S_EMIT) || (state == S_POP_OUT));

  // memory port steering
  always_comb begin
    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    ord_raddr  = '0;
    meta_we    = 1'b0;
    meta_waddr = slot;
    meta_wdata = '0;
    meta_raddr = ord_rdata;
    pkt_we     = 1'b0;
    pkt_waddr  = '0;
    pkt_wdata  = {tag, sq};
    pkt_raddr  = {slot, pj[PW-1:0]};
    case (state)
      S_CLR: begin
        ord_we    = 1'b1;
        ord_waddr = clr[FW-1:0];
        ord_wdata = clr[FW-1:0];
      end
      S_SC_ORD:  ord_raddr = fi[FW-1:0];
      S_NF_RD:   ord_raddr = held[FW-1:0];
      S_OSH_RD: begin
        ord_raddr = fim1[FW-1:0];
        if (fi <= fp) begin
          // slot lands at its position, frame starts with this packet
          ord_we     = 1'b1;
          ord_waddr  = fp[FW-1:0];
          ord_wdata  = slot;
          meta_we    = 1'b1;
          meta_wdata = {CW'(1), nal_ext, SUM_W'(blen), ts};
          pkt_we     = 1'b1;
          pkt_waddr  = {slot, PW'(0)};
        end
      end
      S_OSH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = fi[FW-1:0];
        ord_wdata = ord_rdata;
      end
      S_PSH_RD: begin
        pkt_raddr = {slot, pjm1[PW-1:0]};
        if (pj <= pp) begin
          pkt_we     = 1'b1;
          pkt_waddr  = {slot, pp[PW-1:0]};
          meta_we    = 1'b1;
          meta_wdata = {CW'(cnt + CW'(1)), CW'(nalc + nal_ext), sum_sat, ts};
        end
      end
      S_PSH_WR: begin
        pkt_we    = 1'b1;
        pkt_waddr = {slot, pj[PW-1:0]};
        pkt_wdata = pkt_rdata;
      end
      S_POP_ORD: ord_raddr = '0;
      S_OD_RD: begin
        ord_raddr = fi[FW-1:0];
        if (fi >= held) begin
          // freed slot goes back behind the held frames
          ord_we    = 1'b1;
          ord_waddr = heldm1[FW-1:0];
          ord_wdata = slot;
        end
      end
      S_OD_WR: begin
        ord_we    = 1'b1;
        ord_waddr = fim1[FW-1:0];
        ord_wdata = ord_rdata;
      end
      S_FL_ORD:  ord_raddr = heldm1[FW-1:0];
      default: ;
    endcase
  end

  // position -> slot table; positions at and above held list the free slots
  frjb_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_ord (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // per-slot stamp, byte sum, nal count, packet count
  frjb_ram #(.WIDTH(MW), .DEPTH(MAX_FRAMES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // per-slot packet rows kept in sequence order: tag above seq
  frjb_ram #(.WIDTH(PKW), .DEPTH(PDEPTH)) u_pkt (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (pkt_waddr),
    .wdata (pkt_wdata),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      held      <= '0;
      started   <= 1'b0;
      lps       <= '0;
      start_len <= '0;
      m_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_len <= cfg_wdata;
      end
      if (beat_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          clr <= clr + HW'(1);
          if (clr == HW'(MAX_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_axis_tvalid) begin
            ts        <= s_axis_tdata[31:0];
            sq        <= s_axis_tdata[47:32];
            blen      <= s_axis_tdata[63:48];
            nal       <= s_axis_tdata[64];
            tag       <= s_axis_tdata[80:65];
            res_stamp <= '0;
            case (s_axis_tuser)
              OP_PUSH: begin
                fp    <= '0;
                fi    <= '0;
                fd    <= {1'b0, s_axis_tdata[31:0]};
                fstop <= 1'b0;
                if (late) begin
                  res_status <= ST_LATE;
                  state      <= S_EMIT;
                end else if (held == '0) begin
                  state <= S_NF_RD;
                end else begin
                  state <= S_SC_ORD;
                end
              end
              OP_POP: begin
                if (!started || held == '0) begin
                  res_status <= ST_NOPOP;
                  state      <= S_EMIT;
                end else begin
                  state <= S_POP_ORD;
                end
              end
              OP_FLUSH: begin
                res_status <= ST_FLUSHED;
                if (held == '0) begin
                  res_stamp <= lps;
                  state     <= S_EMIT;
                end else begin
                  state <= S_FL_ORD;
                end
              end
              default: ;  // unused opcode: no result
            endcase
          end
        end

        // scan held frames for a matching stamp, tracking the insert point
        S_SC_ORD:  state <= S_SC_META;
        S_SC_META: begin
          slot  <= ord_rdata;
          state <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (m_rd_stamp == ts) begin
            cnt  <= m_rd_cnt;
            nalc <= m_rd_nal;
            sum  <= m_rd_sum;
            pj   <= '0;
            pp   <= '0;
            sd   <= {1'b0, sq};
            if (m_rd_cnt >= CW'(MAX_PACKETS)) begin
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end else begin
              state <= S_SQ_RD;
            end
          end else begin
            if (!fstop) begin
              if (f_adv) begin
                fp <= fi + HW'(1);
                fd <= f_adj;
              end else begin
                fstop <= 1'b1;
              end
            end
            if ((fi + HW'(1)) == held) begin
              if (held >= HW'(MAX_FRAMES)) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else begin
                state <= S_NF_RD;
              end
            end else begin
              fi    <= fi + HW'(1);
              state <= S_SC_ORD;
            end
          end
        end

        // new frame: take the first free slot, open a gap in the order table
        S_NF_RD:  state <= S_NF_GET;
        S_NF_GET: begin
          slot  <= ord_rdata;
          fi    <= held;
          state <= S_OSH_RD;
        end
        S_OSH_RD: begin
          if (fi > fp) begin
            state <= S_OSH_WR;
          end else begin
            held <= heldp1;
            if (!started && start_new) begin
              started <= 1'b1;
            end
            res_status <= ST_ACCEPTED;
            state      <= S_EMIT;
          end
        end
        S_OSH_WR: begin
          fi    <= fim1;
          state <= S_OSH_RD;
        end

        // existing frame: walk packets for the sequence slot
        S_SQ_RD:  state <= S_SQ_CMP;
        S_SQ_CMP: begin
          if (s_adv) begin
            pp <= pjp1;
            sd <= s_adj;
            if (pjp1 >= cnt) begin
              pj    <= cnt;
              state <= S_PSH_RD;
            end else begin
              pj    <= pjp1;
              state <= S_SQ_RD;
            end
          end else begin
            pj    <= cnt;
            state <= S_PSH_RD;
          end
        end
        S_PSH_RD: begin
          if (pj > pp) begin
            state <= S_PSH_WR;
          end else begin
            if (!started && start_same) begin
              started <= 1'b1;
            end
            res_status <= ST_ACCEPTED;
            state      <= S_EMIT;
          end
        end
        S_PSH_WR: begin
          pj    <= pjm1;
          state <= S_PSH_RD;
        end

        // single-beat result
        S_EMIT: begin
          if (ofree) begin
            m_status <= res_status;
            m_stamp  <= res_stamp;
            m_tag    <= '0;
            m_seq    <= '0;
            m_bytes  <= '0;
            m_nal    <= '0;
            m_pk     <= '0;
            m_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end

        // pop: stream the oldest frame, then close the gap in the order table
        S_POP_ORD:  state <= S_POP_META;
        S_POP_META: begin
          slot  <= ord_rdata;
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          mstamp <= m_rd_stamp;
          sum    <= m_rd_sum;
          nalc   <= m_rd_nal;
          cnt    <= m_rd_cnt;
          pj     <= '0;
          state  <= S_POP_RD;
        end
        S_POP_RD: state <= S_POP_OUT;
        S_POP_OUT: begin
          if (ofree) begin
            m_status <= ST_POPPED;
            m_stamp  <= mstamp;
            m_tag    <= pkt_rdata[PKW-1:SEQ_W];
            m_seq    <= p_rd_seq;
            m_bytes  <= sum;
            m_nal    <= sat_cnt(nalc);
            m_pk     <= sat_cnt(cnt);
            m_last   <= (pjp1 == cnt);
            if (pjp1 == cnt) begin
              lps   <= mstamp;
              fi    <= HW'(1);
              state <= S_OD_RD;
            end else begin
              pj    <= pjp1;
              state <= S_POP_RD;
            end
          end
        end
        S_OD_RD: begin
          if (fi < held) begin
            state <= S_OD_WR;
          end else begin
            held  <= heldm1;
            state <= S_IDLE;
          end
        end
        S_OD_WR: begin
          fi    <= fi + HW'(1);
          state <= S_OD_RD;
        end

        // flush: note the newest stamp and drop every frame
        S_FL_ORD:  state <= S_FL_META;
        S_FL_META: state <= S_FL_LD;
        S_FL_LD: begin
          lps       <= m_rd_stamp;
          res_stamp <= m_rd_stamp;
          held      <= '0;
          state     <= S_EMIT;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = m_status;
  assign m_axis_tlast  = m_last;
  assign m_axis_tdata  = {2'b00, m_pk, m_nal, m_bytes, m_seq, m_tag, m_stamp};

  // checks
  `FRJB_ASSERT_NOW(a_held_bound, 1'b1, held <= HW'(MAX_FRAMES), "frame count above store size")
  `FRJB_ASSERT_NEXT(a_started_sticky, started, started, "output start flag dropped")
  `FRJB_ASSERT_NOW(a_pop_nonempty, m_valid && (m_status == ST_POPPED), m_pk != '0, "popped beat with empty frame")

endmodule
